### design/u2g_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2g_pkg
// Types, constants and lookup tables of the UTF-8 to GSM 7-bit mapper.
// ----------------------------------------------------------------------------
package u2g_pkg;

  localparam logic [6:0] EscSeptet = 7'h1B;
  localparam logic [6:0] ReplReset = 7'h3F;

  localparam logic [7:0] AsciiMax = 8'd127;
  localparam logic [7:0] Lead2Lo  = 8'd194;
  localparam logic [7:0] Lead2Hi  = 8'd223;
  localparam logic [7:0] Lead3Lo  = 8'd224;
  localparam logic [7:0] Lead3Hi  = 8'd239;
  localparam logic [7:0] Lead4Lo  = 8'd240;
  localparam logic [7:0] Lead4Hi  = 8'd244;

  localparam int unsigned ExtCount = 10;
  localparam int unsigned DefCount = 128;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_in;
  } in_t;

  typedef struct packed {
    logic [6:0] septet;
    logic       last_out;
  } out_t;

  typedef struct packed {
    logic [31:0] key;
    logic        last;
  } key_item_t;

  typedef struct packed {
    logic       esc;
    logic [6:0] code;
  } map_t;

  localparam logic [23:0] ExtKeys [ExtCount] = '{
    24'h00000c, 24'h00005e, 24'h00007b, 24'h00007d, 24'h00005c,
    24'h00005b, 24'h00007e, 24'h00005d, 24'h00007c, 24'he282ac
  };

  localparam logic [6:0] ExtCodes [ExtCount] = '{
    7'h0a, 7'h14, 7'h28, 7'h29, 7'h2f, 7'h3c, 7'h3d, 7'h3e, 7'h40, 7'h65
  };

  localparam logic [23:0] DefKeys [DefCount] = '{
    24'h0040, 24'hc2a3, 24'h0024, 24'hc2a5, 24'hc3a8, 24'hc3a9, 24'hc3b9, 24'hc3ac,
    24'hc3b2, 24'hc387, 24'h000a, 24'hc398, 24'hc3b8, 24'h000d, 24'hc385, 24'hc3a5,
    24'hce94, 24'h005f, 24'hcea6, 24'hce93, 24'hce9b, 24'hcea9, 24'hcea0, 24'hcea8,
    24'hcea3, 24'hce98, 24'hce9e, 24'h00a0, 24'hc386, 24'hc3a6, 24'hc39f, 24'hc389,
    24'h0020, 24'h0021, 24'h0022, 24'h0023, 24'hc2a4, 24'h0025, 24'h0026, 24'h0027,
    24'h0028, 24'h0029, 24'h002a, 24'h002b, 24'h002c, 24'h002d, 24'h002e, 24'h002f,
    24'h0030, 24'h0031, 24'h0032, 24'h0033, 24'h0034, 24'h0035, 24'h0036, 24'h0037,
    24'h0038, 24'h0039, 24'h003a, 24'h003b, 24'h003c, 24'h003d, 24'h003e, 24'h003f,
    24'hc2a1, 24'h0041, 24'h0042, 24'h0043, 24'h0044, 24'h0045, 24'h0046, 24'h0047,
    24'h0048, 24'h0049, 24'h004a, 24'h004b, 24'h004c, 24'h004d, 24'h004e, 24'h004f,
    24'h0050, 24'h0051, 24'h0052, 24'h0053, 24'h0054, 24'h0055, 24'h0056, 24'h0057,
    24'h0058, 24'h0059, 24'h005a, 24'hc384, 24'hc396, 24'hc391, 24'hc39c, 24'hc2a7,
    24'hc2bf, 24'h0061, 24'h0062, 24'h0063, 24'h0064, 24'h0065, 24'h0066, 24'h0067,
    24'h0068, 24'h0069, 24'h006a, 24'h006b, 24'h006c, 24'h006d, 24'h006e, 24'h006f,
    24'h0070, 24'h0071, 24'h0072, 24'h0073, 24'h0074, 24'h0075, 24'h0076, 24'h0077,
    24'h0078, 24'h0079, 24'h007a, 24'hc3a4, 24'hc3b6, 24'hc3b1, 24'hc3bc, 24'hc3a0
  };

  // Extension table wins; the escape slot of the default table never matches.
  function automatic map_t lookup(input logic [31:0] key, input logic [6:0] repl);
    map_t m;
    m.esc  = 1'b0;
    m.code = repl;
    for (int i = 0; i < DefCount; i++) begin
      if (i != int'(EscSeptet) && key == {8'h00, DefKeys[i]}) begin
        m.code = 7'(i);
      end
    end
    for (int i = 0; i < ExtCount; i++) begin
      if (key == {8'h00, ExtKeys[i]}) begin
        m.esc  = 1'b1;
        m.code = ExtCodes[i];
      end
    end
    return m;
  endfunction

endpackage

### design/u2g_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2g_fifo
// Small synchronous queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module u2g_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### design/u2g_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2g_front
// Gathers UTF-8 bytes into raw sequence keys, one byte per beat.
// ----------------------------------------------------------------------------
module u2g_front
  import u2g_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_t       item_i,
  output logic      push_o,
  output key_item_t key_o
);

  logic [23:0] gath_q, gath_d;
  logic [1:0]  need_q, need_d;
  logic [1:0]  lead_need, rem;
  logic [31:0] cat;
  logic [7:0]  b;

  assign b   = item_i.byte_in;
  assign cat = {gath_q, b};
  assign rem = need_q - 2'd1;

  always_comb begin
    if (b inside {[Lead2Lo:Lead2Hi]}) begin
      lead_need = 2'd1;
    end else if (b inside {[Lead3Lo:Lead3Hi]}) begin
      lead_need = 2'd2;
    end else if (b inside {[Lead4Lo:Lead4Hi]}) begin
      lead_need = 2'd3;
    end else begin
      lead_need = 2'd0; // ASCII or bad lead: keyed as the byte itself
    end
  end

  always_comb begin
    gath_d      = gath_q;
    need_d      = need_q;
    push_o      = 1'b0;
    key_o.key   = {24'h0, b};
    key_o.last  = item_i.last_in;
    if (accept_i) begin
      if (need_q == 2'd0) begin
        if (lead_need == 2'd0) begin
          push_o = 1'b1;
        end else if (item_i.last_in) begin
          push_o    = 1'b1;
          key_o.key = {24'h0, b} << {lead_need, 3'b000};
        end else begin
          gath_d = {16'h0, b};
          need_d = lead_need;
        end
      end else if (rem == 2'd0 || item_i.last_in) begin
        push_o    = 1'b1;
        key_o.key = cat << {rem, 3'b000};
        gath_d    = '0;
        need_d    = 2'd0;
      end else begin
        gath_d = cat[23:0];
        need_d = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gath_q <= '0;
      need_q <= '0;
    end else begin
      gath_q <= gath_d;
      need_q <= need_d;
    end
  end

endmodule

### design/u2g_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2g_back
// Looks up queued keys and emits one or two septets per key.
// ----------------------------------------------------------------------------
module u2g_back
  import u2g_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  key_item_t  q_data_i,
  output logic       q_pop_o,
  input  logic [6:0] repl_i,
  input  logic       o_full_i,
  output logic       o_push_o,
  output out_t       o_data_o
);

  map_t       m;
  logic       valid_q, esc_q, last_q;
  logic [6:0] code_q;
  logic       emit, done, load;

  assign m        = lookup(q_data_i.key, repl_i);
  assign emit     = valid_q && !o_full_i;
  assign done     = emit && !esc_q;
  assign load     = !q_empty_i && (!valid_q || done);
  assign q_pop_o  = load;
  assign o_push_o = emit;

  assign o_data_o.septet   = esc_q ? EscSeptet : code_q;
  assign o_data_o.last_out = esc_q ? 1'b0 : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      esc_q   <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
      esc_q   <= m.esc;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (emit) begin
      esc_q   <= 1'b0; // escape prefix sent, code follows
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= m.code;
      last_q <= q_data_i.last;
    end
  end

endmodule

### design/utf8_to_gsm7_alphabet_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_gsm7_alphabet_mapper
// UTF-8 byte stream to GSM 7-bit default alphabet septets.
// Throughput: one byte per cycle while the key queue is not full; an escape pair gives two septets.
// Path: a completed key is queued, latched by the lookup stage, then queued for output.
// Reset: clears the gather state and queues, replacement code returns to 63.
// ----------------------------------------------------------------------------
module utf8_to_gsm7_alphabet_mapper
  import u2g_pkg::*;
#(
  parameter int unsigned QueueDepth = 2,
  parameter int unsigned OutDepth   = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_t        item_i,
  output logic       empty,
  input  logic       pop,
  output out_t       result_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  logic [6:0] repl_code_q;
  logic       f_push, q_full, q_empty, q_pop, o_push, o_full;
  key_item_t  f_key, q_key;
  out_t       o_data;
  logic       accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !q_full;
  assign full        = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_code_q <= ReplReset;
    end else if (cfg_valid_i) begin
      repl_code_q <= cfg_data_i;
    end
  end

  u2g_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .push_o   (f_push),
    .key_o    (f_key)
  );

  u2g_fifo #(
    .Width ($bits(key_item_t)),
    .Depth (QueueDepth)
  ) u_key_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_key),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_key),
    .empty_o (q_empty)
  );

  u2g_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_key),
    .q_pop_o   (q_pop),
    .repl_i    (repl_code_q),
    .o_full_i  (o_full),
    .o_push_o  (o_push),
    .o_data_o  (o_data)
  );

  u2g_fifo #(
    .Width ($bits(out_t)),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (o_push),
    .wdata_i (o_data),
    .full_o  (o_full),
    .pop_i   (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

endmodule

### bench/utf8_to_gsm7_alphabet_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_gsm7_alphabet_mapper_tb
// Self-checking bench for the UTF-8 to GSM 7-bit mapper. A directed table
// covers the byte classes, the escape pairs, bad lead bytes and sequences cut
// short by the end of the text. Random text then runs through several
// replacement-code settings. A local septet predictor queues the expected
// beats; every popped beat is checked in order. Both ends idle at random; one
// phase runs with no idling and one holds off the reader at its start so input stalls.
// ----------------------------------------------------------------------------
module utf8_to_gsm7_alphabet_mapper_tb;
  import u2g_pkg::*;

  localparam int DirCount    = 24;
  localparam int PhaseCount  = 7;
  localparam int PhaseItems  = 185;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 10;
  localparam int QuietLimit  = 3000;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  in_t        item_i;
  logic       empty;
  logic       pop;
  out_t       result_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i;

  logic [23:0] ext_keys [ExtCount] = '{
    24'h00000c, 24'h00005e, 24'h00007b, 24'h00007d, 24'h00005c,
    24'h00005b, 24'h00007e, 24'h00005d, 24'h00007c, 24'he282ac
  };
  logic [6:0] ext_codes [ExtCount] = '{
    7'h0a, 7'h14, 7'h28, 7'h29, 7'h2f, 7'h3c, 7'h3d, 7'h3e, 7'h40, 7'h65
  };
  logic [23:0] def_keys [DefCount] = '{
    24'h0040, 24'hc2a3, 24'h0024, 24'hc2a5, 24'hc3a8, 24'hc3a9, 24'hc3b9, 24'hc3ac,
    24'hc3b2, 24'hc387, 24'h000a, 24'hc398, 24'hc3b8, 24'h000d, 24'hc385, 24'hc3a5,
    24'hce94, 24'h005f, 24'hcea6, 24'hce93, 24'hce9b, 24'hcea9, 24'hcea0, 24'hcea8,
    24'hcea3, 24'hce98, 24'hce9e, 24'h00a0, 24'hc386, 24'hc3a6, 24'hc39f, 24'hc389,
    24'h0020, 24'h0021, 24'h0022, 24'h0023, 24'hc2a4, 24'h0025, 24'h0026, 24'h0027,
    24'h0028, 24'h0029, 24'h002a, 24'h002b, 24'h002c, 24'h002d, 24'h002e, 24'h002f,
    24'h0030, 24'h0031, 24'h0032, 24'h0033, 24'h0034, 24'h0035, 24'h0036, 24'h0037,
    24'h0038, 24'h0039, 24'h003a, 24'h003b, 24'h003c, 24'h003d, 24'h003e, 24'h003f,
    24'hc2a1, 24'h0041, 24'h0042, 24'h0043, 24'h0044, 24'h0045, 24'h0046, 24'h0047,
    24'h0048, 24'h0049, 24'h004a, 24'h004b, 24'h004c, 24'h004d, 24'h004e, 24'h004f,
    24'h0050, 24'h0051, 24'h0052, 24'h0053, 24'h0054, 24'h0055, 24'h0056, 24'h0057,
    24'h0058, 24'h0059, 24'h005a, 24'hc384, 24'hc396, 24'hc391, 24'hc39c, 24'hc2a7,
    24'hc2bf, 24'h0061, 24'h0062, 24'h0063, 24'h0064, 24'h0065, 24'h0066, 24'h0067,
    24'h0068, 24'h0069, 24'h006a, 24'h006b, 24'h006c, 24'h006d, 24'h006e, 24'h006f,
    24'h0070, 24'h0071, 24'h0072, 24'h0073, 24'h0074, 24'h0075, 24'h0076, 24'h0077,
    24'h0078, 24'h0079, 24'h007a, 24'hc3a4, 24'hc3b6, 24'hc3b1, 24'hc3bc, 24'hc3a0
  };

  // after reset, replacement code 63
  dir_row_t dir_rows [DirCount] = '{
    '{8'h00, 1'b0, 1'b1, 2'd1, '{ReplReset, 1'b0}, '0},
    '{8'h7f, 1'b0, 1'b1, 2'd1, '{ReplReset, 1'b0}, '0},
    '{8'h40, 1'b0, 1'b1, 2'd1, '{7'h00, 1'b0}, '0},
    '{8'h0c, 1'b0, 1'b1, 2'd2, '{EscSeptet, 1'b0}, '{7'h0a, 1'b0}},
    '{8'h80, 1'b0, 1'b1, 2'd1, '{ReplReset, 1'b0}, '0},
    '{8'hc1, 1'b0, 1'b1, 2'd1, '{ReplReset, 1'b0}, '0},
    '{8'hff, 1'b0, 1'b1, 2'd1, '{ReplReset, 1'b0}, '0},
    '{8'hf5, 1'b1, 1'b1, 2'd1, '{ReplReset, 1'b1}, '0},
    '{8'hc2, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'ha3, 1'b0, 1'b1, 2'd1, '{7'h01, 1'b0}, '0},
    '{8'hdf, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'hbf, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'he2, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h82, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'hac, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'hf0, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h9f, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h98, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h80, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'hf4, 1'b0, 1'b0, 2'd0, '0, '0},
    '{8'h8f, 1'b1, 1'b0, 2'd0, '0, '0},
    '{8'he0, 1'b1, 1'b0, 2'd0, '0, '0},
    '{8'h7e, 1'b1, 1'b1, 2'd2, '{EscSeptet, 1'b0}, '{7'h3d, 1'b1}},
    '{8'h0a, 1'b0, 1'b0, 2'd0, '0, '0}
  };

  logic [23:0] gather_bytes;
  logic [1:0]  need_bytes;
  logic [6:0]  repl_code;
  out_t        step_res [$];
  out_t        septet_q [$];
  logic [7:0]  text_q [$];

  int  fails;
  int  phase_items;
  int  quiet_cycles;
  bit  calm;
  bit  hold_pop;

  utf8_to_gsm7_alphabet_mapper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 21);
  endfunction

  function automatic void add_res(logic [6:0] septet, logic last);
    out_t r;
    r.septet   = septet;
    r.last_out = last;
    step_res.push_back(r);
  endfunction

  function automatic void map_string(logic [31:0] key, logic last);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < ExtCount; i++) begin
      if (!hit && key == {8'h00, ext_keys[i]}) begin
        add_res(EscSeptet, 1'b0);
        add_res(ext_codes[i], last);
        hit = 1'b1;
      end
    end
    for (int i = 0; i < DefCount; i++) begin
      if (!hit && i != int'(EscSeptet) && key == {8'h00, def_keys[i]}) begin
        add_res(7'(i), last);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      add_res(repl_code, last);
    end
  endfunction

  function automatic void advance_gsm(in_t it);
    logic [31:0] key;
    logic [1:0]  need;
    step_res.delete();
    if (need_bytes == 2'd0) begin
      if (it.byte_in <= AsciiMax) begin
        map_string({24'h0, it.byte_in}, it.last_in);
        return;
      end
      if (it.byte_in >= Lead2Lo && it.byte_in <= Lead2Hi) begin
        need = 2'd1;
      end else if (it.byte_in >= Lead3Lo && it.byte_in <= Lead3Hi) begin
        need = 2'd2;
      end else if (it.byte_in >= Lead4Lo && it.byte_in <= Lead4Hi) begin
        need = 2'd3;
      end else begin
        add_res(repl_code, it.last_in);
        return;
      end
      if (it.last_in) begin
        key = {24'h0, it.byte_in} << (8 * need);
        map_string(key, 1'b1);
      end else begin
        gather_bytes = {16'h0, it.byte_in};
        need_bytes   = need;
      end
      return;
    end
    key        = {gather_bytes, it.byte_in};
    need_bytes = need_bytes - 2'd1;
    if (need_bytes == 2'd0 || it.last_in) begin
      key          = key << (8 * need_bytes);
      gather_bytes = '0;
      need_bytes   = '0;
      map_string(key, it.last_in);
    end else begin
      gather_bytes = key[23:0];
    end
  endfunction

  task automatic send_beat(dir_row_t row);
    in_t it;
    it.byte_in = row.b;
    it.last_in = row.last;
    while (idle_now()) begin
      push <= 1'b0;
      @(posedge clk_i);
      @(negedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    advance_gsm(it);
    if (row.typed) begin
      if (row.n > 0) septet_q.push_back(row.r0);
      if (row.n > 1) septet_q.push_back(row.r1);
    end else begin
      foreach (step_res[i]) septet_q.push_back(step_res[i]);
    end
    phase_items++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (septet_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_repl(logic [6:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    repl_code = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int push_key(logic [23:0] key);
    int len;
    len = 1;
    if (key[23:16] != 8'h00) begin
      text_q.push_back(key[23:16]);
      len++;
    end
    if (key[23:8] != 16'h0000) begin
      text_q.push_back(key[15:8]);
      len++;
    end
    text_q.push_back(key[7:0]);
    return len;
  endfunction

  task automatic send_text();
    int       n_chars;
    int       kind;
    int       char_len;
    int       cut;
    dir_row_t row;
    text_q.delete();
    char_len = 1;
    n_chars  = $urandom_range(1, 12);
    if ($urandom_range(0, 99) < 6) begin
      repeat (2 * n_chars) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (n_chars) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          text_q.push_back(8'($urandom_range(0, 127)));
          char_len = 1;
        end else if (kind < 50) begin
          char_len = push_key(ext_keys[$urandom_range(0, ExtCount - 1)]);
        end else if (kind < 70) begin
          char_len = push_key(def_keys[$urandom_range(0, DefCount - 1)]);
        end else if (kind < 78) begin
          text_q.push_back(8'($urandom_range(Lead2Lo, Lead2Hi)));
          text_q.push_back(8'($urandom_range(0, 255)));
          char_len = 2;
        end else if (kind < 84) begin
          text_q.push_back(8'($urandom_range(Lead3Lo, Lead3Hi)));
          repeat (2) text_q.push_back(8'($urandom_range(0, 255)));
          char_len = 3;
        end else if (kind < 89) begin
          text_q.push_back(8'($urandom_range(Lead4Lo, Lead4Hi)));
          repeat (3) text_q.push_back(8'($urandom_range(0, 255)));
          char_len = 4;
        end else if (kind < 95) begin
          if ($urandom_range(0, 1)) begin
            text_q.push_back(8'($urandom_range(128, 193)));
          end else begin
            text_q.push_back(8'($urandom_range(245, 255)));
          end
          char_len = 1;
        end else begin
          text_q.push_back(8'($urandom_range(0, 255)));
          char_len = 1;
        end
      end
      // text ends inside a multibyte character
      if (char_len > 1 && $urandom_range(0, 99) < 12) begin
        cut = $urandom_range(1, char_len - 1);
        repeat (cut) void'(text_q.pop_back());
      end
    end
    foreach (text_q[i]) begin
      row      = '0;
      row.b    = text_q[i];
      row.last = (i == text_q.size() - 1);
      send_beat(row);
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && pop && !empty) begin
      if (septet_q.size() == 0) begin
        $error("unexpected beat: septet %0d last_out %0d", result_o.septet,
               result_o.last_out);
        fails++;
      end else begin
        want = septet_q.pop_front();
        if (result_o.septet !== want.septet) begin
          $error("septet: expected %0d, actual %0d", want.septet, result_o.septet);
          fails++;
        end
        if (result_o.last_out !== want.last_out) begin
          $error("last_out: expected %0d, actual %0d", want.last_out,
                 result_o.last_out);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pop) begin
        hold_pop = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      pop <= !idle_now();
    end
  end

  initial begin
    logic [6:0] value;
    push         = 1'b0;
    item_i       = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    rst_ni       = 1'b0;
    fails        = 0;
    phase_items  = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    hold_pop     = 1'b0;
    gather_bytes = '0;
    need_bytes   = '0;
    repl_code    = ReplReset;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DirCount; i++) begin
      send_beat(dir_rows[i]);
    end
    wait_drained();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       value = 7'd0;
        1:       value = 7'd127;
        4:       value = ReplReset;
        6:       value = 7'd127;
        default: value = 7'($urandom_range(0, 127));
      endcase
      write_repl(value);
      calm        = (ph == 2);
      hold_pop    = (ph == 4);
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        send_text();
      end
      wait_drained();
      calm = 1'b0;
    end

    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
design/u2g_pkg.sv
design/u2g_fifo.sv
design/u2g_front.sv
design/u2g_back.sv
design/utf8_to_gsm7_alphabet_mapper.sv
bench/utf8_to_gsm7_alphabet_mapper_tb.sv
